/* rtl/fcsk_pkg.sv */
package fcsk_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned WIDTH      = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned NUM_FIELDS = 4;

  localparam int unsigned TDATA_W    = NUM_FIELDS * WIDTH;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  // gain lies in [0, 1.0], so one bit above the fraction
  localparam int unsigned K_W        = FRAC_BITS + 1;
  localparam int unsigned DIVIDEND_W = WIDTH + FRAC_BITS;
  localparam int unsigned CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam logic [K_W-1:0]   ONE_FIX       = K_W'(1) << FRAC_BITS;
  localparam logic [WIDTH-1:0] MEAS_NOISE_RST = WIDTH'(65536);
  localparam logic [WIDTH-1:0] PROC_NOISE_RST = WIDTH'(6554);
  localparam logic [WIDTH-1:0] INIT_COV_RST   = WIDTH'(65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_PREDICT = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_INIT    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_NOISE = 2'd0,
    REG_PROC_NOISE = 2'd1,
    REG_INIT_COV   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PREDICT,
    OP_LOAD,
    OP_CORRECT
  } lane_op_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_MUL,
    L_APPLY
  } lane_state_e;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_e;

  typedef struct packed {
    logic [WIDTH-1:0] meas_noise;
    logic [WIDTH-1:0] proc_noise;
    logic [WIDTH-1:0] init_cov;
  } cfg_t;

  typedef struct packed {
    logic              start;
    lane_op_e          op;
    logic [WIDTH-1:0]  z;
  } lane_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [WIDTH-1:0]  est;
  } lane_stat_t;

endpackage

/* rtl/fcsk_div.sv */
module fcsk_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [fcsk_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [fcsk_pkg::WIDTH:0]           divisor_i,
  output logic                               done_o,
  output logic [fcsk_pkg::DIVIDEND_W-1:0]    quotient_o
);
  import fcsk_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WIDTH:0]        rem_q, rem_d;
  logic [WIDTH:0]        dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [WIDTH+1:0]      rem_sh;
  logic                  fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? (WIDTH+1)'(rem_sh - {1'b0, dvs_q}) : rem_sh[WIDTH:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/fcsk_lane.sv */
module fcsk_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fcsk_pkg::cfg_t         cfg_i,
  input  fcsk_pkg::lane_cmd_t    cmd_i,
  output fcsk_pkg::lane_stat_t   stat_o
);
  import fcsk_pkg::*;

  lane_state_e              state_q, state_d;
  logic [WIDTH-1:0]         est_q, est_d;
  logic [WIDTH-1:0]         cov_q, cov_d;
  logic [WIDTH:0]           mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [K_W-1:0]           k_q, k_d;
  logic [K_W+WIDTH:0]       corr_prod_q, corr_prod_d;
  logic [K_W+WIDTH-1:0]     cov_prod_q, cov_prod_d;

  logic [WIDTH:0]           sum_s;
  logic [WIDTH:0]           pred_sum;
  logic [WIDTH:0]           innov;
  logic [WIDTH:0]           est_new;
  logic [WIDTH:0]           corr;
  logic                     div_start;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    div_quo;
  logic                     correct_go;

  assign sum_s    = {1'b0, cov_q} + {1'b0, cfg_i.meas_noise};
  assign pred_sum = {1'b0, cov_q} + {1'b0, cfg_i.proc_noise};
  assign innov    = {cmd_i.z[WIDTH-1], cmd_i.z} - {est_q[WIDTH-1], est_q};
  assign corr     = corr_prod_q[FRAC_BITS +: (WIDTH + 1)];
  assign est_new  = neg_q ? ({est_q[WIDTH-1], est_q} - corr)
                          : ({est_q[WIDTH-1], est_q} + corr);

  // a zero innovation variance leaves the lane untouched
  assign correct_go = cmd_i.start && (cmd_i.op == OP_CORRECT) && (sum_s != '0);

  fcsk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({cov_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (sum_s),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE:  if (correct_go) state_d = L_DIV;
      L_DIV:   if (div_done) state_d = L_MUL;
      L_MUL:   state_d = L_APPLY;
      L_APPLY: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    div_start   = (state_q == L_IDLE) && correct_go;
    stat_o.busy = (state_q != L_IDLE);
    stat_o.est  = est_q;
  end

  always_comb begin
    est_d       = est_q;
    cov_d       = cov_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    k_d         = k_q;
    corr_prod_d = corr_prod_q;
    cov_prod_d  = cov_prod_q;
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            OP_PREDICT: cov_d = pred_sum[WIDTH] ? '1 : pred_sum[WIDTH-1:0];
            OP_LOAD: begin
              est_d = cmd_i.z;
              cov_d = cfg_i.init_cov;
            end
            OP_CORRECT: begin
              neg_d = innov[WIDTH];
              mag_d = innov[WIDTH] ? (WIDTH+1)'(-innov) : innov;
            end
            default: ;
          endcase
        end
      end
      L_DIV: begin
        if (div_done) begin
          k_d = (div_quo > DIVIDEND_W'(ONE_FIX)) ? ONE_FIX : div_quo[K_W-1:0];
        end
      end
      L_MUL: begin
        corr_prod_d = (K_W+WIDTH+1)'(k_q) * (K_W+WIDTH+1)'(mag_q);
        cov_prod_d  = (K_W+WIDTH)'(ONE_FIX - k_q) * (K_W+WIDTH)'(cov_q);
      end
      L_APPLY: begin
        est_d = est_new[WIDTH-1:0];
        cov_d = cov_prod_q[FRAC_BITS +: WIDTH];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      est_q   <= '0;
      cov_q   <= '0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      cov_q   <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    k_q         <= k_d;
    corr_prod_q <= corr_prod_d;
    cov_prod_q  <= cov_prod_d;
  end

endmodule

/* rtl/four_channel_scalar_kalman.sv */
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid_i/tready_o       tdata meas_x..meas_h, tuser kind
// m_axis    out        m_axis_tvalid_o/tready_i       tdata est_x..est_h, tuser ready_flag
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// one item at a time; predict, init and no-op items need no divide, while an
// update item on an initialised filter waits on the 48-step serial divider
// for the gain in each lane (all four lanes divide side by side)
// rst_ni clears estimates, covariances and the initialised flag, loads register defaults
// a held result stalls the next completion, not the following input transfer
module four_channel_scalar_kalman (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // meas_x, meas_y, meas_w, meas_h
  input  logic [fcsk_pkg::TDATA_W-1:0]      s_axis_tdata_i,
  // kind
  input  logic [fcsk_pkg::KIND_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // est_x, est_y, est_w, est_h
  output logic [fcsk_pkg::TDATA_W-1:0]      m_axis_tdata_o,
  // ready_flag
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fcsk_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fcsk_pkg::WIDTH-1:0]        cfg_data_i
);
  import fcsk_pkg::*;

  top_state_e        state_q, state_d;
  cfg_t              cfg_q, cfg_d;
  logic              init_q, init_d;
  logic              out_valid_q, out_valid_d;
  logic [TDATA_W-1:0] out_data_q, out_data_d;
  logic              out_flag_q, out_flag_d;

  logic              in_xfer;
  logic              lanes_busy;
  logic              out_free;
  logic              load_out;
  lane_op_e          op;
  lane_cmd_t         cmd [LANES];
  lane_stat_t        stat [LANES];
  logic [LANES-1:0]  busy_vec;
  logic [TDATA_W-1:0] merged;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    case (kind_e'(s_axis_tuser_i))
      KIND_PREDICT: op = init_q ? OP_PREDICT : OP_NONE;
      KIND_UPDATE:  op = init_q ? OP_CORRECT : OP_LOAD;
      KIND_INIT:    op = OP_LOAD;
      default:      op = OP_NONE;
    endcase
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign cmd[i].start = in_xfer;
    assign cmd[i].op    = op;
    assign cmd[i].z     = s_axis_tdata_i[(i % NUM_FIELDS) * WIDTH +: WIDTH];
    assign busy_vec[i]  = stat[i].busy;

    fcsk_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .cmd_i  (cmd[i]),
      .stat_o (stat[i])
    );
  end

  // merge: gather lane estimates into one result word
  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_merge
    if (f < LANES) begin : g_used
      assign merged[f * WIDTH +: WIDTH] = stat[f].est;
    end else begin : g_zero
      assign merged[f * WIDTH +: WIDTH] = '0;
    end
  end

  assign lanes_busy = |busy_vec;
  assign out_free   = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: if (in_xfer) state_d = TOP_BUSY;
      TOP_BUSY: if (!lanes_busy && out_free) state_d = TOP_IDLE;
      default:  state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == TOP_IDLE);
    load_out        = (state_q == TOP_BUSY) && !lanes_busy && out_free;
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MEAS_NOISE: cfg_d.meas_noise = cfg_data_i;
        REG_PROC_NOISE: cfg_d.proc_noise = cfg_data_i;
        REG_INIT_COV:   cfg_d.init_cov   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    init_d      = init_q || (in_xfer && (op == OP_LOAD));
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_flag_d  = out_flag_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = merged;
      out_flag_d  = init_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= TOP_IDLE;
      cfg_q.meas_noise <= MEAS_NOISE_RST;
      cfg_q.proc_noise <= PROC_NOISE_RST;
      cfg_q.init_cov   <= INIT_COV_RST;
      init_q           <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_flag_q <= out_flag_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_flag_q;

endmodule

/* rtl/fcsk_checker.sv */
module fcsk_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [fcsk_pkg::TDATA_W-1:0]      m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);
  import fcsk_pkg::*;

  logic flag_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o) begin
      flag_seen_q <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one item in flight: no second transfer right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // a new result only appears at the end of a busy spell
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result raised without an item at work");

  // once initialised, the flag never drops
  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && flag_seen_q |-> m_axis_tuser_o)
    else $error("initialised flag dropped");

endmodule

bind four_channel_scalar_kalman fcsk_checker u_fcsk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/four_channel_scalar_kalman_tb.sv */
module four_channel_scalar_kalman_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcsk_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 130;

  // kind and register index codes that the package leaves unnamed
  localparam logic [KIND_W-1:0]    KIND_NOP   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [WIDTH-1:0] MAX_POS  = 32'h7fff_ffff;
  localparam logic [WIDTH-1:0] MIN_NEG  = 32'h8000_0000;
  localparam logic [WIDTH-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [WIDTH-1:0] ZERO     = 32'h0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]                kind;
    logic [NUM_FIELDS-1:0][WIDTH-1:0] meas;
  } box_item_t;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][WIDTH-1:0] box;
    logic                             live;
  } box_est_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready_o;
  logic [TDATA_W-1:0]     s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [TDATA_W-1:0]     m_tdata_o;
  logic                   m_tuser_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WIDTH-1:0]       cfg_data = '0;

  // filter state mirrored by the predictor
  logic signed [WIDTH-1:0] est [LANES];
  logic [WIDTH-1:0]        cov [LANES];
  logic                    filter_live;
  logic [WIDTH-1:0]        r_noise = MEAS_NOISE_RST;
  logic [WIDTH-1:0]        q_noise = PROC_NOISE_RST;
  logic [WIDTH-1:0]        p_init  = INIT_COV_RST;

  box_item_t  pending_q [$];
  box_est_t   box_est_q [$];
  box_item_t  cur_item;
  box_est_t   want;
  logic [WIDTH-1:0] track [NUM_FIELDS];

  logic s_taken = 1'b0;
  bit   in_idle = 1'b1;
  bit   out_idle = 1'b1;
  int   in_gap = 0;
  int   out_stall = 0;
  int   err_cnt = 0;
  int   cycles = 0;

  four_channel_scalar_kalman i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata_o),
    .m_axis_tuser_o  (m_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void load_box(input logic [NUM_FIELDS-1:0][WIDTH-1:0] z);
    for (int i = 0; i < LANES; i++) begin
      est[i] = z[i];
      cov[i] = p_init;
    end
    filter_live = 1'b1;
  endfunction

  function automatic box_est_t track_box(input logic [KIND_W-1:0] kind,
                                         input logic [NUM_FIELDS-1:0][WIDTH-1:0] z);
    box_est_t      res;
    logic [WIDTH:0] sum;
    logic [63:0]   gain;
    logic [63:0]   mag;
    logic [63:0]   corr;
    longint        diff;
    case (kind)
      KIND_PREDICT: begin
        if (filter_live) begin
          for (int i = 0; i < LANES; i++) begin
            sum = {1'b0, cov[i]} + {1'b0, q_noise};
            cov[i] = sum[WIDTH] ? ALL_ONES : sum[WIDTH-1:0];
          end
        end
      end
      KIND_UPDATE: begin
        if (!filter_live) begin
          load_box(z);
        end else begin
          for (int i = 0; i < LANES; i++) begin
            sum = {1'b0, cov[i]} + {1'b0, r_noise};
            // zero innovation variance leaves the lane alone
            if (sum != '0) begin
              gain = (64'(cov[i]) << FRAC_BITS) / 64'(sum);
              if (gain > 64'(ONE_FIX)) gain = 64'(ONE_FIX);
              diff = longint'($signed(z[i])) - longint'(est[i]);
              mag  = (diff < 0) ? -diff : diff;
              corr = (gain * mag) >> FRAC_BITS;
              est[i] = (diff < 0) ? est[i] - WIDTH'(corr) : est[i] + WIDTH'(corr);
              cov[i] = WIDTH'(((64'(ONE_FIX) - gain) * 64'(cov[i])) >> FRAC_BITS);
            end
          end
        end
      end
      KIND_INIT: load_box(z);
      default: ;
    endcase
    for (int i = 0; i < NUM_FIELDS; i++) res.box[i] = (i < LANES) ? est[i] : ZERO;
    res.live = filter_live;
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [WIDTH-1:0] exp_v,
                                        input logic [WIDTH-1:0] got_v);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WIDTH-1:0] pick_reg(input logic [WIDTH-1:0] dflt);
    case ($urandom_range(0, 4))
      0: return ZERO;
      1: return ALL_ONES;
      2: return $urandom;
      3: return $urandom_range(0, 32'h0004_0000);
      default: return dflt;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_coord(input int lane);
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return track[lane] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    if (r < 92) return $urandom;
    case ($urandom_range(0, 3))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return ZERO;
      default: return ALL_ONES;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_PREDICT;
    if (r < 86) return KIND_UPDATE;
    if (r < 95) return KIND_INIT;
    return KIND_NOP;
  endfunction

  function automatic void queue_item(input logic [KIND_W-1:0] kind, input logic [WIDTH-1:0] x,
                                     input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] w,
                                     input logic [WIDTH-1:0] h);
    box_item_t it;
    it.kind = kind;
    it.meas = {h, w, y, x};
    pending_q.push_back(it);
  endfunction

  function automatic void queue_random(input logic [KIND_W-1:0] kind);
    queue_item(kind, pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MEAS_NOISE: r_noise = val;
      REG_PROC_NOISE: q_noise = val;
      REG_INIT_COV:   p_init  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || s_tvalid || box_est_q.size() != 0) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!s_tvalid || s_taken) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_item.meas;
        s_tuser  <= cur_item.kind;
        in_gap   <= (in_idle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (out_idle && $urandom_range(0, 3) == 0) out_stall <= gap_len();
    end
  end

  // monitor: check results, then predict for the input transfer
  always @(posedge clk_i) begin
    s_taken <= s_tvalid && s_tready_o;
    if (m_tvalid_o && m_tready) begin
      if (box_est_q.size() == 0) begin
        flag_mismatch("unexpected result", ZERO, m_tdata_o[WIDTH-1:0]);
      end else begin
        want = box_est_q.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (m_tdata_o[i*WIDTH +: WIDTH] !== want.box[i])
            flag_mismatch($sformatf("est lane %0d", i), want.box[i], m_tdata_o[i*WIDTH +: WIDTH]);
        end
        if (m_tuser_o !== want.live)
          flag_mismatch("ready flag", WIDTH'(want.live), WIDTH'(m_tuser_o));
      end
    end
    if (s_tvalid && s_tready_o) box_est_q.push_back(track_box(s_tuser, s_tdata));
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[four_channel_scalar_kalman] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LANES; i++) begin
      est[i] = '0;
      cov[i] = '0;
    end
    filter_live = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: predict and no-op before init, update doing the init
    queue_item(KIND_PREDICT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    queue_item(KIND_NOP, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    queue_item(KIND_UPDATE, 32'h0001_0000, 32'h0002_0000, 32'h0010_0000, 32'h0008_0000);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_UPDATE, 32'h0001_8000, 32'h0001_0000, 32'h0011_0000, 32'h0007_0000);
    queue_item(KIND_UPDATE, MAX_POS, MIN_NEG, ZERO, ALL_ONES);
    queue_item(KIND_INIT, MAX_POS, MIN_NEG, ZERO, ALL_ONES);
    queue_item(KIND_UPDATE, MIN_NEG, MAX_POS, ALL_ONES, ZERO);
    queue_item(KIND_NOP, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_PREDICT, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    wait_drain();

    // zero innovation variance, plus a write to the unused index
    write_reg(REG_MEAS_NOISE, ZERO);
    write_reg(REG_PROC_NOISE, ZERO);
    write_reg(REG_INIT_COV, ZERO);
    write_reg(REG_UNUSED, ALL_ONES);
    queue_item(KIND_INIT, 32'h0005_0000, 32'hfffb_0000, 32'h0020_0000, 32'h0018_0000);
    queue_item(KIND_UPDATE, MAX_POS, MIN_NEG, ALL_ONES, ZERO);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_UPDATE, MIN_NEG, MAX_POS, ZERO, ALL_ONES);
    wait_drain();

    // covariance saturation and a gain of exactly one
    write_reg(REG_PROC_NOISE, ALL_ONES);
    write_reg(REG_INIT_COV, ALL_ONES);
    queue_item(KIND_INIT, MIN_NEG, MAX_POS, ALL_ONES, ZERO);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_UPDATE, MAX_POS, MIN_NEG, ZERO, ALL_ONES);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    queue_item(KIND_UPDATE, 32'h0001_0000, 32'hffff_0000, 32'h0040_0000, 32'h0030_0000);
    wait_drain();

    // largest noise and covariance
    write_reg(REG_MEAS_NOISE, ALL_ONES);
    write_reg(REG_PROC_NOISE, 32'h0000_0001);
    queue_item(KIND_INIT, ZERO, ALL_ONES, MIN_NEG, MAX_POS);
    queue_item(KIND_UPDATE, MAX_POS, MIN_NEG, ZERO, ALL_ONES);
    queue_item(KIND_PREDICT, ZERO, ZERO, ZERO, ZERO);
    wait_drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      write_reg(REG_MEAS_NOISE, pick_reg(MEAS_NOISE_RST));
      write_reg(REG_PROC_NOISE, pick_reg(PROC_NOISE_RST));
      write_reg(REG_INIT_COV, pick_reg(INIT_COV_RST));
      for (int i = 0; i < NUM_FIELDS; i++)
        track[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      if ($urandom_range(0, 1) == 0) queue_random(KIND_INIT);
      repeat (PHASE_ITEMS) queue_random(pick_kind());
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && box_est_q.size() == 0) begin
      $display("[four_channel_scalar_kalman] OK");
    end else begin
      $display("[four_channel_scalar_kalman] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fcsk_pkg.sv
rtl/fcsk_div.sv
rtl/fcsk_lane.sv
rtl/four_channel_scalar_kalman.sv
rtl/fcsk_checker.sv
tb/four_channel_scalar_kalman_tb.sv
